// ===== design/accelerating_repeat_focus_selector_assert.svh =====
// assertion macros for the accelerating repeat focus selector
// no dependencies; included by arfs_step, which checks its own logic
`ifndef ACCELERATING_REPEAT_FOCUS_SELECTOR_ASSERT_SVH
`define ACCELERATING_REPEAT_FOCUS_SELECTOR_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define ARFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ARFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ARFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define ARFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/arfs_pkg.sv =====
// shared types, constants and helpers for the accelerating repeat focus selector
// no dependencies
package arfs_pkg;

    localparam int MAX_ITEMS = 256;
    // largest usable list length
    localparam logic [8:0] COUNT_LIMIT = 9'((MAX_ITEMS < 256) ? MAX_ITEMS : 256);

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [8:0]  RST_ITEM_COUNT = 9'd1;
    localparam logic [7:0]  RST_DELAY0     = 8'd10;
    localparam logic [7:0]  RST_DELAY1     = 8'd5;
    localparam logic [7:0]  RST_DELAY2     = 8'd2;
    localparam logic [7:0]  RST_THRESH0    = 8'd2;
    localparam logic [7:0]  RST_THRESH1    = 8'd2;

    localparam logic [15:0] PRESS_MAX = 16'hFFFF;

    localparam logic [1:0] LEVEL_SLOW = 2'd0;
    localparam logic [1:0] LEVEL_MID  = 2'd1;
    localparam logic [1:0] LEVEL_FAST = 2'd2;

    typedef enum logic [2:0] {
        REG_ITEM_COUNT = 3'd0,
        REG_DELAY0     = 3'd1,
        REG_DELAY1     = 3'd2,
        REG_DELAY2     = 3'd3,
        REG_THRESH0    = 3'd4,
        REG_THRESH1    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [8:0] item_count;
        logic [7:0] delay0;
        logic [7:0] delay1;
        logic [7:0] delay2;
        logic [7:0] thresh0;
        logic [7:0] thresh1;
    } t_cfg;

    typedef struct packed {
        logic en;
        logic down;
        logic up;
    } t_step_req;

    typedef struct packed {
        logic [7:0] focus_index;
        logic       focus_changed;
    } t_step_rsp;

    // zero counts as one entry, too large is limited
    function automatic logic [8:0] eff_count(input logic [8:0] n);
        logic [8:0] r;
        r = n;
        if (r == 9'd0) r = 9'd1;
        if (r > COUNT_LIMIT) r = COUNT_LIMIT;
        return r;
    endfunction

endpackage

// ===== design/arfs_cfg.sv =====
// configuration register file behind the apb-style port
// depends on arfs_pkg
module arfs_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [arfs_pkg::ADDR_W-1:0]   paddr,
    input  logic [arfs_pkg::DATA_W-1:0]   pwdata,
    output logic [arfs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output arfs_pkg::t_cfg                o_cfg
);

    arfs_pkg::t_cfg   r_cfg;
    arfs_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = arfs_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.item_count <= arfs_pkg::RST_ITEM_COUNT;
            r_cfg.delay0     <= arfs_pkg::RST_DELAY0;
            r_cfg.delay1     <= arfs_pkg::RST_DELAY1;
            r_cfg.delay2     <= arfs_pkg::RST_DELAY2;
            r_cfg.thresh0    <= arfs_pkg::RST_THRESH0;
            r_cfg.thresh1    <= arfs_pkg::RST_THRESH1;
        end else if (w_wr) begin
            case (w_idx)
                arfs_pkg::REG_ITEM_COUNT: r_cfg.item_count <= pwdata[8:0];
                arfs_pkg::REG_DELAY0:     r_cfg.delay0     <= pwdata[7:0];
                arfs_pkg::REG_DELAY1:     r_cfg.delay1     <= pwdata[7:0];
                arfs_pkg::REG_DELAY2:     r_cfg.delay2     <= pwdata[7:0];
                arfs_pkg::REG_THRESH0:    r_cfg.thresh0    <= pwdata[7:0];
                arfs_pkg::REG_THRESH1:    r_cfg.thresh1    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            arfs_pkg::REG_ITEM_COUNT: prdata[8:0] = r_cfg.item_count;
            arfs_pkg::REG_DELAY0:     prdata[7:0] = r_cfg.delay0;
            arfs_pkg::REG_DELAY1:     prdata[7:0] = r_cfg.delay1;
            arfs_pkg::REG_DELAY2:     prdata[7:0] = r_cfg.delay2;
            arfs_pkg::REG_THRESH0:    prdata[7:0] = r_cfg.thresh0;
            arfs_pkg::REG_THRESH1:    prdata[7:0] = r_cfg.thresh1;
            default:                  prdata = '0;
        endcase
    end

endmodule

// ===== design/arfs_step.sv =====
// repeat state (focus, press counts, speed level, wait counter) and its per-beat update
// depends on arfs_pkg and accelerating_repeat_focus_selector_assert.svh
`include "accelerating_repeat_focus_selector_assert.svh"

module arfs_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  arfs_pkg::t_cfg      i_cfg,
    input  arfs_pkg::t_step_req i_req,
    output arfs_pkg::t_step_rsp o_rsp
);

    logic [7:0]  r_pos,   n_pos;
    logic [15:0] r_down,  n_down;
    logic [15:0] r_up,    n_up;
    logic [1:0]  r_level, n_level;
    logic [7:0]  r_wait,  n_wait;

    logic [8:0]  w_count;
    logic [7:0]  w_delay;
    logic [15:0] w_mine;
    logic [15:0] w_mine_inc;
    logic [1:0]  w_lvl;
    logic [7:0]  w_thresh;
    logic        w_fire;
    logic        w_held;

    assign w_count = arfs_pkg::eff_count(i_cfg.item_count);
    assign w_held  = i_req.down || i_req.up;
    // down wins over up
    assign w_mine  = i_req.down ? r_down : r_up;

    always_comb begin
        case (r_level)
            arfs_pkg::LEVEL_SLOW: w_delay = i_cfg.delay0;
            arfs_pkg::LEVEL_MID:  w_delay = i_cfg.delay1;
            default:              w_delay = i_cfg.delay2;
        endcase
    end

    assign w_fire     = (w_mine == 16'd0) || (r_wait == w_delay);
    assign w_mine_inc = (w_mine < arfs_pkg::PRESS_MAX) ? w_mine + 16'd1 : w_mine;
    // a fresh press restarts at the slow level
    assign w_lvl      = (w_mine == 16'd0) ? arfs_pkg::LEVEL_SLOW : r_level;
    assign w_thresh   = (w_lvl == arfs_pkg::LEVEL_SLOW) ? i_cfg.thresh0 : i_cfg.thresh1;

    always_comb begin
        n_pos   = r_pos;
        n_down  = r_down;
        n_up    = r_up;
        n_level = r_level;
        n_wait  = r_wait;
        if (i_req.en) begin
            if (!w_held) begin
                n_down  = '0;
                n_up    = '0;
                n_level = arfs_pkg::LEVEL_SLOW;
                n_wait  = '0;
            end else if (w_fire) begin
                n_wait = '0;
                if (w_lvl < arfs_pkg::LEVEL_FAST && w_mine_inc == {8'd0, w_thresh})
                    n_level = w_lvl + 2'd1;
                else
                    n_level = w_lvl;
                if (i_req.down) begin
                    n_down = w_mine_inc;
                    n_up   = '0;
                    if (({1'b0, r_pos} + 9'd1) < w_count) n_pos = r_pos + 8'd1;
                    else                                  n_pos = '0;
                end else begin
                    n_up   = w_mine_inc;
                    n_down = '0;
                    if (r_pos != 8'd0) n_pos = r_pos - 8'd1;
                    else               n_pos = 8'(w_count - 9'd1);
                end
            end else begin
                n_wait = r_wait + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_down  <= '0;
            r_up    <= '0;
            r_level <= arfs_pkg::LEVEL_SLOW;
            r_wait  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_down  <= n_down;
            r_up    <= n_up;
            r_level <= n_level;
            r_wait  <= n_wait;
        end
    end

    assign o_rsp.focus_index   = n_pos;
    assign o_rsp.focus_changed = (n_pos != r_pos);

    `ARFS_ASSERT_NOW(a_one_dir_counting, i_clk, i_rst_n, 1'b1, (r_down == 16'd0) || (r_up == 16'd0), "both press counters nonzero")
    `ARFS_ASSERT_NOW(a_level_range, i_clk, i_rst_n, 1'b1, r_level != 2'd3, "speed level out of range")
    `ARFS_ASSERT_NEXT(a_release_clears, i_clk, i_rst_n, i_req.en && !i_req.down && !i_req.up, (r_down == 16'd0) && (r_up == 16'd0) && (r_wait == 8'd0) && (r_level == arfs_pkg::LEVEL_SLOW), "release did not clear repeat state")
    `ARFS_ASSERT_NEXT(a_first_press_moves, i_clk, i_rst_n, i_req.en && i_req.down && (r_down == 16'd0), (r_down == 16'd1) && (r_wait == 8'd0), "first down beat did not count")

endmodule

// ===== design/accelerating_repeat_focus_selector.sv =====
// top level: input register, repeat logic, result register and configuration port
// depends on arfs_pkg, arfs_cfg and arfs_step
//
//  channel  direction  handshake          payload
//  in       to block   i_valid / o_stall  i_down_held, i_up_held
//  out      from block o_valid / i_stall  o_focus_index, o_focus_changed
//  cfg      to block   psel/penable/pwrite paddr, pwdata, prdata
//
// one beat per cycle sustained while the output is not stalled; an accepted beat passes through
// the input register at the accepting edge, then the repeat state update into the result register
// while the output is stalled the result is held and the beat waits in the input register
// reset is synchronous active low and clears valid flags and repeat state to zero and config registers to defaults
// a held result does not block intake while the input register is free

module accelerating_repeat_focus_selector (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_down_held,
    input  logic                        i_up_held,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_focus_index,
    output logic                        o_focus_changed,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [arfs_pkg::ADDR_W-1:0] paddr,
    input  logic [arfs_pkg::DATA_W-1:0] pwdata,
    output logic [arfs_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    arfs_pkg::t_cfg      w_cfg;
    arfs_pkg::t_step_req w_req;
    arfs_pkg::t_step_rsp w_rsp;

    logic       r_in_vld;
    logic       r_in_down;
    logic       r_in_up;
    logic       r_out_vld;
    logic [7:0] r_out_index;
    logic       r_out_changed;
    logic       w_out_free;
    logic       w_in_take;

    assign w_out_free = !r_out_vld || !i_stall;
    assign w_in_take  = !r_in_vld || w_out_free;
    assign o_stall    = !w_in_take;

    assign w_req.en   = r_in_vld && w_out_free;
    assign w_req.down = r_in_down;
    assign w_req.up   = r_in_up;

    arfs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    arfs_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_take) r_in_vld <= i_valid;
            if (w_out_free) r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take && i_valid) begin
            r_in_down <= i_down_held;
            r_in_up   <= i_up_held;
        end
        if (w_req.en) begin
            r_out_index   <= w_rsp.focus_index;
            r_out_changed <= w_rsp.focus_changed;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_focus_index   = r_out_index;
    assign o_focus_changed = r_out_changed;

endmodule

// ===== sim/tb_accelerating_repeat_focus_selector.sv =====
// testbench for the accelerating repeat focus selector: directed table, long holds, random frames
// depends on arfs_pkg and accelerating_repeat_focus_selector; results checked against a local model
module tb_accelerating_repeat_focus_selector;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic                        i_down_held;
    logic                        i_up_held;
    logic                        o_valid;
    logic                        i_stall;
    logic [7:0]                  o_focus_index;
    logic                        o_focus_changed;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [arfs_pkg::ADDR_W-1:0] paddr;
    logic [arfs_pkg::DATA_W-1:0] pwdata;
    logic [arfs_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    accelerating_repeat_focus_selector u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_down_held     (i_down_held),
        .i_up_held       (i_up_held),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_focus_index   (o_focus_index),
        .o_focus_changed (o_focus_changed),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    typedef struct packed {
        logic       set_count;
        logic [8:0] count;
        logic       down;
        logic       up;
        logic       typed;
        logic [7:0] idx;
        logic       chg;
    } t_dir_row;

    // local copy of the block's configuration and repeat state
    arfs_pkg::t_cfg      cfg_mirror;
    logic [7:0]          focus_pos;
    logic [15:0]         down_cnt;
    logic [15:0]         up_cnt;
    logic [1:0]          level;
    logic [7:0]          wait_cnt;

    arfs_pkg::t_step_rsp focus_expected [$];
    int                  mismatch_count;
    logic                quiet;
    t_dir_row            dir_rows [0:22];

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial begin
        #200000;
        $display("tb_accelerating_repeat_focus_selector: errors");
        $finish;
    end

    task automatic press_dir(input logic is_down, inout logic [15:0] mine,
                             inout logic [15:0] other);
        logic [7:0] dly;
        logic [8:0] n;
        case (level)
            arfs_pkg::LEVEL_SLOW: dly = cfg_mirror.delay0;
            arfs_pkg::LEVEL_MID:  dly = cfg_mirror.delay1;
            default:              dly = cfg_mirror.delay2;
        endcase
        n = cfg_mirror.item_count;
        if (n == 9'd0) n = 9'd1;
        if (n > arfs_pkg::COUNT_LIMIT) n = arfs_pkg::COUNT_LIMIT;
        if (mine == 16'd0 || wait_cnt == dly) begin
            if (mine == 16'd0) level = arfs_pkg::LEVEL_SLOW;
            if (mine != arfs_pkg::PRESS_MAX) mine = mine + 16'd1;
            if (level == arfs_pkg::LEVEL_SLOW) begin
                if (mine == {8'd0, cfg_mirror.thresh0}) level = arfs_pkg::LEVEL_MID;
            end else if (level == arfs_pkg::LEVEL_MID) begin
                if (mine == {8'd0, cfg_mirror.thresh1}) level = arfs_pkg::LEVEL_FAST;
            end
            other = 16'd0;
            wait_cnt = 8'd0;
            if (is_down) begin
                focus_pos = ({1'b0, focus_pos} + 9'd1 < n) ? focus_pos + 8'd1 : 8'd0;
            end else begin
                // an index beyond the count still just steps down by one
                focus_pos = (focus_pos != 8'd0) ? focus_pos - 8'd1 : n[7:0] - 8'd1;
            end
        end else begin
            wait_cnt = wait_cnt + 8'd1;
        end
    endtask

    task automatic predict_focus(input logic down, input logic up,
                                 output arfs_pkg::t_step_rsp rsp);
        logic [7:0] prev;
        prev = focus_pos;
        if (down) begin
            press_dir(1'b1, down_cnt, up_cnt);
        end else if (up) begin
            press_dir(1'b0, up_cnt, down_cnt);
        end else begin
            down_cnt = 16'd0;
            up_cnt = 16'd0;
            level = arfs_pkg::LEVEL_SLOW;
            wait_cnt = 8'd0;
        end
        rsp.focus_index = focus_pos;
        rsp.focus_changed = (focus_pos != prev);
    endtask

    // called just after a falling edge, returns just after a falling edge once the frame has been accepted
    task automatic send_frame(input logic down, input logic up, input logic typed,
                              input logic [7:0] idx, input logic chg);
        arfs_pkg::t_step_rsp rsp;
        while (!quiet && $urandom_range(0, 99) < 7) begin
            i_valid <= 1'b0;
            i_down_held <= 1'($urandom);
            i_up_held <= 1'($urandom);
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_down_held <= down;
        i_up_held <= up;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        predict_focus(down, up, rsp);
        if (typed) begin
            rsp.focus_index = idx;
            rsp.focus_changed = chg;
        end
        focus_expected.push_back(rsp);
        @(negedge i_clk);
    endtask

    task automatic hold_frames(input logic down, input logic up, input int frames);
        repeat (frames) send_frame(down, up, 1'b0, 8'd0, 1'b0);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (focus_expected.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_write(input arfs_pkg::t_reg_idx which, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {which, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        case (which)
            arfs_pkg::REG_ITEM_COUNT: cfg_mirror.item_count = value[8:0];
            arfs_pkg::REG_DELAY0:     cfg_mirror.delay0 = value[7:0];
            arfs_pkg::REG_DELAY1:     cfg_mirror.delay1 = value[7:0];
            arfs_pkg::REG_DELAY2:     cfg_mirror.delay2 = value[7:0];
            arfs_pkg::REG_THRESH0:    cfg_mirror.thresh0 = value[7:0];
            arfs_pkg::REG_THRESH1:    cfg_mirror.thresh1 = value[7:0];
            default:                  ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // idle with psel low so the next setup starts on a later edge
        @(negedge i_clk);
    endtask

    task automatic set_config(input int count, input int d0, input int d1, input int d2,
                              input int t0, input int t1);
        wait_drained();
        apb_write(arfs_pkg::REG_ITEM_COUNT, 32'(count));
        apb_write(arfs_pkg::REG_DELAY0, 32'(d0));
        apb_write(arfs_pkg::REG_DELAY1, 32'(d1));
        apb_write(arfs_pkg::REG_DELAY2, 32'(d2));
        apb_write(arfs_pkg::REG_THRESH0, 32'(t0));
        apb_write(arfs_pkg::REG_THRESH1, 32'(t1));
    endtask

    // mostly clean holds and releases, some frames of noise
    task automatic run_traffic(input int frames, input int max_hold);
        int   sent;
        int   len;
        logic dir_down;
        logic both;
        sent = 0;
        while (sent < frames) begin
            if ($urandom_range(0, 9) < 8) begin
                dir_down = 1'($urandom);
                both = ($urandom_range(0, 3) == 0);
                len = $urandom_range(1, max_hold);
                hold_frames(dir_down | both, !dir_down | both, len);
                sent += len;
                len = $urandom_range(0, 3);
                hold_frames(1'b0, 1'b0, len);
                sent += len;
            end else begin
                len = $urandom_range(1, 8);
                repeat (len) send_frame(1'($urandom), 1'($urandom), 1'b0, 8'd0, 1'b0);
                sent += len;
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= !quiet && ($urandom_range(0, 99) < 7);
        end
    end

    always @(posedge i_clk) begin
        arfs_pkg::t_step_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (focus_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected beat: index %0d changed %0b",
                             o_focus_index, o_focus_changed);
            end else begin
                want = focus_expected.pop_front();
                if (o_focus_index !== want.focus_index
                        || o_focus_changed !== want.focus_changed) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: index exp %0d got %0d, changed exp %0b got %0b",
                                 want.focus_index, o_focus_index,
                                 want.focus_changed, o_focus_changed);
                end
            end
        end
    end

    initial begin
        int         hold_max;
        int         ph;
        int         waited;
        logic [8:0] rc;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_down_held = 1'b0;
        i_up_held = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet = 1'b0;
        mismatch_count = 0;
        cfg_mirror = '{arfs_pkg::RST_ITEM_COUNT, arfs_pkg::RST_DELAY0,
                       arfs_pkg::RST_DELAY1, arfs_pkg::RST_DELAY2,
                       arfs_pkg::RST_THRESH0, arfs_pkg::RST_THRESH1};
        focus_pos = 8'd0;
        down_cnt = 16'd0;
        up_cnt = 16'd0;
        level = arfs_pkg::LEVEL_SLOW;
        wait_cnt = 8'd0;

        // set_count, count, down, up, typed, index, changed
        dir_rows = '{
            '{1'b0, 9'd0,   1'b0, 1'b0, 1'b1, 8'd0,   1'b0},
            '{1'b0, 9'd0,   1'b1, 1'b0, 1'b1, 8'd0,   1'b0},
            '{1'b0, 9'd0,   1'b0, 1'b1, 1'b1, 8'd0,   1'b0},
            '{1'b0, 9'd0,   1'b1, 1'b1, 1'b1, 8'd0,   1'b0},
            '{1'b1, 9'd256, 1'b0, 1'b0, 1'b1, 8'd0,   1'b0},
            '{1'b0, 9'd0,   1'b0, 1'b1, 1'b1, 8'd255, 1'b1},
            '{1'b0, 9'd0,   1'b0, 1'b0, 1'b1, 8'd255, 1'b0},
            '{1'b0, 9'd0,   1'b1, 1'b0, 1'b1, 8'd0,   1'b1},
            '{1'b0, 9'd0,   1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
            '{1'b0, 9'd0,   1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
            '{1'b0, 9'd0,   1'b1, 1'b1, 1'b0, 8'd0,   1'b0},
            '{1'b0, 9'd0,   1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
            '{1'b0, 9'd0,   1'b1, 1'b1, 1'b0, 8'd0,   1'b0},
            '{1'b0, 9'd0,   1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
            '{1'b0, 9'd0,   1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
            '{1'b0, 9'd0,   1'b1, 1'b1, 1'b0, 8'd0,   1'b0},
            '{1'b0, 9'd0,   1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
            '{1'b0, 9'd0,   1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
            '{1'b0, 9'd0,   1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
            '{1'b0, 9'd0,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
            '{1'b1, 9'd0,   1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
            '{1'b1, 9'd511, 1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
            '{1'b0, 9'd0,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0}
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].set_count) begin
                wait_drained();
                apb_write(arfs_pkg::REG_ITEM_COUNT, 32'(dir_rows[k].count));
            end
            send_frame(dir_rows[k].down, dir_rows[k].up, dir_rows[k].typed,
                       dir_rows[k].idx, dir_rows[k].chg);
        end

        // index left beyond a lowered count, then a down and an up move
        set_config(200, 0, 0, 0, 0, 0);
        hold_frames(1'b1, 1'b0, 20);
        hold_frames(1'b0, 1'b0, 1);
        wait_drained();
        apb_write(arfs_pkg::REG_ITEM_COUNT, 32'd10);
        hold_frames(1'b1, 1'b0, 1);
        hold_frames(1'b0, 1'b0, 1);
        wait_drained();
        apb_write(arfs_pkg::REG_ITEM_COUNT, 32'd200);
        hold_frames(1'b1, 1'b0, 20);
        hold_frames(1'b0, 1'b0, 1);
        wait_drained();
        apb_write(arfs_pkg::REG_ITEM_COUNT, 32'd10);
        hold_frames(1'b0, 1'b1, 2);
        hold_frames(1'b0, 1'b0, 1);

        // wait counter overruns a delay lowered mid-hold and wraps past 255
        set_config(7, 200, 5, 2, 200, 200);
        hold_frames(1'b1, 1'b0, 2);
        wait_drained();
        apb_write(arfs_pkg::REG_DELAY0, 32'd0);
        quiet <= 1'b1;
        hold_frames(1'b1, 1'b0, 256);
        hold_frames(1'b0, 1'b0, 1);
        quiet <= 1'b0;

        for (ph = 0; ph < 10; ph++) begin
            hold_max = 8;
            case (ph)
                0: set_config(5, 3, 2, 1, 2, 3);
                1: set_config(256, 0, 0, 0, 1, 1);
                2: set_config(2, 255, 255, 255, 1, 1);
                3: set_config(0, 2, 1, 0, 0, 0);
                4: set_config(1, 1, 1, 1, 255, 255);
                default: begin
                    rc = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                                     : 9'($urandom_range(1, 12));
                    set_config(rc,
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 6),
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 6),
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 6),
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(1, 5),
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(1, 5));
                end
            endcase
            quiet <= (ph == 1 || ph == 2);
            run_traffic(10, hold_max);
            quiet <= 1'b0;
        end

        i_valid <= 1'b0;
        waited = 0;
        while (focus_expected.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        mismatch_count += focus_expected.size();
        if (mismatch_count == 0) begin
            $display("tb_accelerating_repeat_focus_selector: clean");
        end else begin
            $display("tb_accelerating_repeat_focus_selector: errors");
        end
        $finish;
    end

endmodule
